[rtl/tctf_pkg.sv]
`timescale 1ns / 1ps
// tctf_pkg: shared constants and types for the threshold crossing time finder
// no dependencies; imported by every module of the block

package tctf_pkg;

    // default widths of times and altitudes
    localparam int TIME_BITS_DEF = 32;
    localparam int ALT_BITS_DEF  = 32;

    // configuration register index codes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_START = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_END   = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } seq_state_t;

endpackage

[rtl/tctf_regs.sv]
`timescale 1ns / 1ps
// tctf_regs: apb-style configuration registers (threshold, window start, window end)
// depends on tctf_pkg for the register index codes

module tctf_regs
    import tctf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ALT_BITS  = ALT_BITS_DEF,
    parameter int DATA_W    = 32,
    parameter int ADDR_W    = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    output logic signed [ALT_BITS-1:0]  threshold_mm,
    output logic [TIME_BITS-1:0]        window_start_ms,
    output logic [TIME_BITS-1:0]        window_end_ms
);

    localparam int ADDR_SHIFT = (DATA_W > 32) ? 3 : 2;

    logic signed [ALT_BITS-1:0] threshold_reg;
    logic [TIME_BITS-1:0]       window_start_reg;
    logic [TIME_BITS-1:0]       window_end_reg;
    logic [REG_IDX_W-1:0]       reg_idx;
    logic                       wr_en;

    assign reg_idx = paddr[ADDR_SHIFT +: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            window_start_reg <= '0;
            window_end_reg   <= '1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRESHOLD:    threshold_reg    <= pwdata[ALT_BITS-1:0];
                REG_WINDOW_START: window_start_reg <= pwdata[TIME_BITS-1:0];
                REG_WINDOW_END:   window_end_reg   <= pwdata[TIME_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD:    prdata = DATA_W'($unsigned(threshold_reg));
            REG_WINDOW_START: prdata = DATA_W'(window_start_reg);
            REG_WINDOW_END:   prdata = DATA_W'(window_end_reg);
            default:          prdata = '0;
        endcase
    end

    assign threshold_mm    = threshold_reg;
    assign window_start_ms = window_start_reg;
    assign window_end_ms   = window_end_reg;

endmodule

[rtl/tctf_muldiv.sv]
`timescale 1ns / 1ps
// tctf_muldiv: bit-serial floor(num * d / den) with remainder, one bit of d per cycle
// depends on tctf_pkg for default widths; requires num < den

module tctf_muldiv
    import tctf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ALT_BITS  = ALT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ALT_BITS-1:0]  num,
    input  logic [ALT_BITS-1:0]  den,
    input  logic [TIME_BITS-1:0] d,
    output logic                 done,
    output logic [TIME_BITS-1:0] quot,
    output logic [ALT_BITS-1:0]  rem
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ALT_BITS-1:0]  num_reg, den_reg;
    logic [TIME_BITS-1:0] d_reg, d_next;
    logic [ALT_BITS-1:0]  r_reg, r_next;
    logic [TIME_BITS-1:0] q_reg, q_next;

    logic [ALT_BITS:0]    r_dbl, r_half, s_add;
    logic                 c_dbl, c_add;

    // one step: double the remainder, then add num if the next bit of d is set
    always_comb
    begin
        r_dbl  = {r_reg, 1'b0};
        c_dbl  = r_dbl >= {1'b0, den_reg};
        r_half = c_dbl ? (r_dbl - {1'b0, den_reg}) : r_dbl;
        s_add  = r_half + {1'b0, num_reg};
        c_add  = d_reg[TIME_BITS-1] && (s_add >= {1'b0, den_reg});
        if (!d_reg[TIME_BITS-1])
            r_next = r_half[ALT_BITS-1:0];
        else if (c_add)
            r_next = ALT_BITS'(s_add - {1'b0, den_reg});
        else
            r_next = s_add[ALT_BITS-1:0];
        q_next = {q_reg[TIME_BITS-2:0], 1'b0} + TIME_BITS'(c_dbl) + TIME_BITS'(c_add);
        d_next = {d_reg[TIME_BITS-2:0], 1'b0};
        cnt_next  = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != CNT_W'(1));
        done_next = busy_reg && (cnt_reg == CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(TIME_BITS);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            d_reg   <= d;
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            d_reg <= d_next;
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

[rtl/threshold_crossing_time_finder_top.sv]
`timescale 1ns / 1ps
// threshold_crossing_time_finder_top: sample sequencer, series state and result register
// depends on tctf_pkg, tctf_regs and tctf_muldiv

// Feed timestamped altitude samples on the sample channel; a sample marked
// last_sample yields one result transfer with crossing_found and the time of
// the last downward crossing of threshold_mm inside the window (0 if none).
// A sample that holds no crossing is handled in the cycle it is taken. A sample that
// completes a crossing pair runs the shared bit-serial multiply-divide, one
// time bit per cycle, and holds the sample channel until it is done; a last
// sample then passes through ST_EMIT to load the result register. Samples keep
// flowing while a result waits to be taken, until the next last sample.
// Registers must be written only while the block is idle; the block itself does not enforce this.
module threshold_crossing_time_finder_top
    import tctf_pkg::*;
#(
    parameter  int TIME_BITS = TIME_BITS_DEF,
    parameter  int ALT_BITS  = ALT_BITS_DEF,
    localparam int DATA_W    = ((TIME_BITS > 32) || (ALT_BITS > 32)) ? 64 : 32,
    localparam int ADDR_W    = (DATA_W > 32) ? 5 : 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic [TIME_BITS-1:0]        sample_time_ms,
    input  logic signed [ALT_BITS-1:0]  sample_altitude_mm,
    input  logic                        last_sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        crossing_found,
    output logic [TIME_BITS-1:0]        crossing_time_ms
);

    logic signed [ALT_BITS-1:0] threshold_mm;
    logic [TIME_BITS-1:0]       window_start_ms;
    logic [TIME_BITS-1:0]       window_end_ms;

    seq_state_t state_reg, state_next;

    logic [TIME_BITS-1:0]       prev_time_reg;
    logic signed [ALT_BITS-1:0] prev_alt_reg;
    logic                       have_prev_reg;
    logic                       window_passed_reg;
    logic                       found_reg;
    logic [TIME_BITS-1:0]       crossing_reg;
    logic [TIME_BITS-1:0]       base_time_reg;
    logic                       backward_reg;
    logic                       last_reg;

    logic                       result_valid_reg;
    logic                       out_found_reg;
    logic [TIME_BITS-1:0]       out_time_reg;

    logic                       sample_xfer, result_xfer;
    logic                       pair_active, passes_window, is_crossing, start_calc;
    logic                       keep_sample, backward, result_load;
    logic [TIME_BITS-1:0]       time_step;
    logic [ALT_BITS-1:0]        md_num, md_den;
    logic                       md_done;
    logic [TIME_BITS-1:0]       md_quot;
    logic [ALT_BITS-1:0]        md_rem;
    logic [TIME_BITS-1:0]       crossing_time;

    tctf_regs #(
        .TIME_BITS (TIME_BITS),
        .ALT_BITS  (ALT_BITS),
        .DATA_W    (DATA_W),
        .ADDR_W    (ADDR_W)
    ) u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .threshold_mm    (threshold_mm),
        .window_start_ms (window_start_ms),
        .window_end_ms   (window_end_ms)
    );

    tctf_muldiv #(
        .TIME_BITS (TIME_BITS),
        .ALT_BITS  (ALT_BITS)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_calc),
        .num   (md_num),
        .den   (md_den),
        .d     (time_step),
        .done  (md_done),
        .quot  (md_quot),
        .rem   (md_rem)
    );

    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign result_xfer  = result_valid_reg && !result_stall;
    assign result_valid = result_valid_reg;
    assign crossing_found   = out_found_reg;
    assign crossing_time_ms = out_time_reg;

    // pair decisions on the incoming sample against the stored previous one
    always_comb
    begin
        pair_active   = !window_passed_reg && have_prev_reg && (sample_time_ms >= window_start_ms);
        passes_window = pair_active && (prev_time_reg > window_end_ms);
        is_crossing   = pair_active && !passes_window
                        && (prev_alt_reg >= threshold_mm)
                        && (sample_altitude_mm < threshold_mm);
        start_calc    = sample_xfer && is_crossing;
        keep_sample   = !window_passed_reg && !passes_window;
        backward      = sample_time_ms < prev_time_reg;
        time_step     = backward ? (prev_time_reg - sample_time_ms)
                                 : (sample_time_ms - prev_time_reg);
        md_num        = ALT_BITS'($unsigned(prev_alt_reg - threshold_mm));
        md_den        = ALT_BITS'($unsigned(prev_alt_reg - sample_altitude_mm));
        // backward steps round toward the earlier time
        crossing_time = backward_reg
                        ? (base_time_reg - md_quot - TIME_BITS'(md_rem != '0))
                        : (base_time_reg + md_quot);
    end

    always_comb
    begin
        state_next  = state_reg;
        result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    if (is_crossing)
                        state_next = ST_CALC;
                    else if (last_sample)
                        state_next = ST_EMIT;
                end
            end
            ST_CALC:
            begin
                if (md_done)
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg     <= '0;
            prev_alt_reg      <= '0;
            have_prev_reg     <= 1'b0;
            window_passed_reg <= 1'b0;
            found_reg         <= 1'b0;
            crossing_reg      <= '0;
        end
        else if (result_load)
        begin
            prev_time_reg     <= '0;
            prev_alt_reg      <= '0;
            have_prev_reg     <= 1'b0;
            window_passed_reg <= 1'b0;
            found_reg         <= 1'b0;
            crossing_reg      <= '0;
        end
        else if (state_reg == ST_CALC && md_done)
        begin
            found_reg    <= 1'b1;
            crossing_reg <= crossing_time;
        end
        else if (sample_xfer)
        begin
            if (passes_window)
                window_passed_reg <= 1'b1;
            if (keep_sample)
            begin
                prev_time_reg <= sample_time_ms;
                prev_alt_reg  <= sample_altitude_mm;
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            base_time_reg <= prev_time_reg;
            backward_reg  <= backward;
            last_reg      <= last_sample;
        end
    end

    // result register, refilled in the same cycle it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_load)
            result_valid_reg <= 1'b1;
        else if (result_xfer)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_found_reg <= found_reg;
            out_time_reg  <= found_reg ? crossing_reg : '0;
        end
    end

    a_done_in_calc : assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == ST_CALC)
        else $error("divider finished outside of calc state");

    a_no_found_zero_time : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !out_found_reg) |-> out_time_reg == '0)
        else $error("result without crossing carries a nonzero time");

    a_plain_sample_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
        (sample_xfer && !is_crossing && !last_sample) |=> state_reg == ST_IDLE)
        else $error("sample without crossing did not complete in one cycle");

    a_emit_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        (sample_xfer && !is_crossing && last_sample) |=> state_reg == ST_EMIT)
        else $error("last sample did not lead to result load");

endmodule

[tb/threshold_crossing_time_finder_top_tb.sv]
`timescale 1ns / 1ps
// threshold_crossing_time_finder_top_tb: self-checking bench for the threshold crossing time finder
// depends on tctf_pkg and threshold_crossing_time_finder_top; drives samples and registers,
// predicts each series result and compares every result transfer against it

module threshold_crossing_time_finder_top_tb;
    import tctf_pkg::*;

    localparam int TW            = TIME_BITS_DEF;
    localparam int AW            = ALT_BITS_DEF;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 144;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam longint ALT_MIN  = -64'sd2147483648;
    localparam longint ALT_MAX  = 64'sd2147483647;
    localparam longint TIME_MAX = 64'sd4294967295;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [31:0]            t_or_value;
        logic [AW-1:0]          alt;
        logic                   last;
        logic                   typed;
        logic                   exp_found;
        logic [TW-1:0]          exp_at_ms;
    } stim_row_t;

    typedef struct packed {
        logic           found;
        logic [TW-1:0]  at_ms;
    } crossing_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [3:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    logic [TW-1:0]          sample_time_ms = '0;
    logic signed [AW-1:0]   sample_altitude_mm = '0;
    logic                   last_sample = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   crossing_found;
    logic [TW-1:0]          crossing_time_ms;

    // predictor copy of registers and series state
    logic signed [AW-1:0]   cfg_threshold = '0;
    logic [TW-1:0]          cfg_win_start = '0;
    logic [TW-1:0]          cfg_win_end = '1;
    logic [TW-1:0]          prev_time_ms = '0;
    logic signed [AW-1:0]   prev_alt_mm = '0;
    bit                     have_prev = 1'b0;
    bit                     window_over = 1'b0;
    bit                     found_any = 1'b0;
    logic [TW-1:0]          crossing_at = '0;

    crossing_t              expected_crossings[$];
    stim_row_t              directed_rows[$];
    int                     mismatch_count = 0;
    int                     cycle_count = 0;
    bit                     idling = 1'b1;
    bit                     sender_calm = 1'b0;
    int                     stall_left = 0;
    int                     calm_left = 0;

    threshold_crossing_time_finder_top DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .sample_time_ms     (sample_time_ms),
        .sample_altitude_mm (sample_altitude_mm),
        .last_sample        (last_sample),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .crossing_found     (crossing_found),
        .crossing_time_ms   (crossing_time_ms)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // next crossing state for one accepted sample; returns 1 with the series result on a last sample
    function automatic bit predict_crossing(input logic [TW-1:0] t, input logic signed [AW-1:0] alt,
                                            input logic last, output crossing_t res);
        longint unsigned num, den, d, prod, q, r;
        res = '0;
        if (!window_over)
        begin
            if (have_prev && t >= cfg_win_start)
            begin
                if (prev_time_ms > cfg_win_end)
                    window_over = 1'b1;
                else if (prev_alt_mm >= cfg_threshold && alt < cfg_threshold)
                begin
                    num = longint'(prev_alt_mm) - longint'(cfg_threshold);
                    den = longint'(prev_alt_mm) - longint'(alt);
                    d = (t >= prev_time_ms) ? t - prev_time_ms : prev_time_ms - t;
                    prod = num * d;
                    q = prod / den;
                    r = prod % den;
                    // backwards step still rounds toward the earlier time
                    if (t >= prev_time_ms)
                        crossing_at = prev_time_ms + q[TW-1:0];
                    else
                        crossing_at = prev_time_ms - q[TW-1:0] - ((r != 0) ? 32'd1 : 32'd0);
                    found_any = 1'b1;
                end
            end
            if (!window_over)
            begin
                prev_time_ms = t;
                prev_alt_mm = alt;
                have_prev = 1'b1;
            end
        end
        if (!last)
            return 1'b0;
        res.found = found_any;
        res.at_ms = found_any ? crossing_at : '0;
        prev_time_ms = '0;
        prev_alt_mm = '0;
        have_prev = 1'b0;
        window_over = 1'b0;
        found_any = 1'b0;
        crossing_at = '0;
        return 1'b1;
    endfunction

    function automatic stim_row_t smp(input logic [TW-1:0] t, input logic [AW-1:0] a,
                                      input logic l);
        return '{ROW_SAMPLE, REG_THRESHOLD, t, a, l, 1'b0, 1'b0, '0};
    endfunction

    function automatic stim_row_t smp_exp(input logic [TW-1:0] t, input logic [AW-1:0] a,
                                          input logic l, input logic f, input logic [TW-1:0] at);
        return '{ROW_SAMPLE, REG_THRESHOLD, t, a, l, 1'b1, f, at};
    endfunction

    function automatic stim_row_t cfg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
        return '{ROW_CONFIG, idx, v, '0, 1'b0, 1'b0, 1'b0, '0};
    endfunction

    function automatic logic [TW-1:0] clamp_time(input longint v);
        if (v < 0)
            return '0;
        if (v > TIME_MAX)
            return '1;
        return v[TW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] clamp_alt(input longint v);
        if (v < ALT_MIN)
            return ALT_MIN[AW-1:0];
        if (v > ALT_MAX)
            return ALT_MAX[AW-1:0];
        return v[AW-1:0];
    endfunction

    // write a register, read it back, and keep the predictor copy in step
    task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_THRESHOLD:    cfg_threshold = value;
            REG_WINDOW_START: cfg_win_start = value;
            REG_WINDOW_END:   cfg_win_end = value;
            default:          ;
        endcase
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input logic [TW-1:0] t, input logic [AW-1:0] a, input logic last,
                               input logic typed, input logic f, input logic [TW-1:0] at);
        crossing_t res;
        bit has_result;
        @(negedge clk);
        sample_valid <= 1'b1;
        sample_time_ms <= t;
        sample_altitude_mm <= a;
        last_sample <= last;
        do @(posedge clk); while (sample_stall);
        has_result = predict_crossing(t, a, last, res);
        if (typed)
        begin
            res.found = f;
            res.at_ms = at;
        end
        if (has_result)
            expected_crossings.push_back(res);
    endtask

    task automatic sender_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
        end
    endtask

    task automatic maybe_pause();
        if (idling && !sender_calm && $urandom_range(4, 0) == 0)
            sender_gap($urandom_range(15, 1));
    endtask

    task automatic drain_results();
        sender_gap(1);
        while (expected_crossings.size() != 0)
            @(posedge clk);
    endtask

    // a crossing pair may still be in the divider after the last result
    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result stall: random bursts, with quiet stretches in between
    always @(negedge clk)
    begin
        if (!idling)
            result_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (calm_left != 0)
        begin
            result_stall <= 1'b0;
            calm_left <= calm_left - 1;
        end
        else if ($urandom_range(5, 0) == 0)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(14, 0);
        end
        else
        begin
            result_stall <= 1'b0;
            if ($urandom_range(39, 0) == 0)
                calm_left <= $urandom_range(300, 100);
        end
    end

    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_crossings.size() == 0)
                report_mismatch($sformatf("result transfer with none expected: found=%0b t=%0d",
                                          crossing_found, crossing_time_ms));
            else
            begin
                want = expected_crossings.pop_front();
                if (crossing_found !== want.found)
                    report_mismatch($sformatf("crossing_found %0b, expected %0b",
                                              crossing_found, want.found));
                if (crossing_time_ms !== want.at_ms)
                    report_mismatch($sformatf("crossing_time_ms %0d, expected %0d",
                                              crossing_time_ms, want.at_ms));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        logic [TW-1:0] st, anchor, c_start, c_end;
        logic [31:0] c_thr;
        logic signed [AW-1:0] sa;
        longint cur_t, cur_a, dt;
        int items_sent, n;
        bit noisy;

        // default registers: threshold 0, full window
        directed_rows.push_back(smp_exp(100, 5000, 1'b1, 1'b0, 0));
        directed_rows.push_back(smp(1000, 1000, 1'b0));
        directed_rows.push_back(smp_exp(2000, -1000, 1'b1, 1'b1, 1500));
        directed_rows.push_back(smp(0, 32'h7fffffff, 1'b0));
        directed_rows.push_back(smp_exp(32'hffffffff, 32'h80000000, 1'b1, 1'b1, 32'h7fffffff));
        // time going backwards, with and without a remainder
        directed_rows.push_back(smp(5000, 10, 1'b0));
        directed_rows.push_back(smp(1000, -10, 1'b0));
        directed_rows.push_back(smp(5000, 10, 1'b0));
        directed_rows.push_back(smp(1000, -20, 1'b1));
        // previous altitude on the threshold counts, current on it does not
        directed_rows.push_back(smp(10, 0, 1'b0));
        directed_rows.push_back(smp_exp(20, -1, 1'b1, 1'b1, 10));
        directed_rows.push_back(smp(10, 5, 1'b0));
        directed_rows.push_back(smp_exp(20, 0, 1'b1, 1'b0, 0));
        // the later of two crossings is kept; upward crossing ignored
        directed_rows.push_back(smp(0, 100, 1'b0));
        directed_rows.push_back(smp(100, -100, 1'b0));
        directed_rows.push_back(smp(200, 100, 1'b0));
        directed_rows.push_back(smp_exp(300, -100, 1'b1, 1'b1, 250));
        directed_rows.push_back(cfg(REG_THRESHOLD, 500));
        directed_rows.push_back(cfg(REG_WINDOW_START, 1000));
        directed_rows.push_back(cfg(REG_WINDOW_END, 2000));
        // sample before window start still becomes the previous sample
        directed_rows.push_back(smp(500, 1000, 1'b0));
        directed_rows.push_back(smp(900, 1000, 1'b0));
        directed_rows.push_back(smp(1200, 0, 1'b1));
        // previous sample past window end closes the series
        directed_rows.push_back(smp(1500, 1000, 1'b0));
        directed_rows.push_back(smp(2500, 1000, 1'b0));
        directed_rows.push_back(smp(2600, 0, 1'b0));
        directed_rows.push_back(smp_exp(2700, 0, 1'b1, 1'b0, 0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG)
            begin
                settle_block();
                program_reg(row.reg_idx, row.t_or_value);
            end
            else
            begin
                send_sample(row.t_or_value, row.alt, row.last, row.typed, row.exp_found,
                            row.exp_at_ms);
                maybe_pause();
            end
        end

        items_sent = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    c_thr = '0;
                    c_start = '0;
                    c_end = '1;
                end
                2:
                begin
                    c_thr = 32'h7fffffff;
                    c_start = '0;
                    c_end = '1;
                end
                3:
                begin
                    c_thr = 32'h80000000;
                    c_start = '0;
                    c_end = '0;
                end
                4:
                begin
                    c_thr = $urandom_range(4000, 0) - 2000;
                    c_start = '1;
                    c_end = '1;
                end
                5:
                begin
                    c_thr = $urandom;
                    c_start = $urandom;
                    c_end = $urandom;
                end
                6:
                begin
                    c_thr = $urandom_range(20000, 0) - 10000;
                    c_start = '0;
                    c_end = $urandom_range(100000, 0);
                end
                default:
                begin
                    c_thr = $urandom_range(200000, 0) - 100000;
                    c_start = $urandom_range(50000, 0);
                    c_end = c_start + $urandom_range(200000, 1000);
                end
            endcase
            settle_block();
            program_reg(REG_THRESHOLD, c_thr);
            program_reg(REG_WINDOW_START, c_start);
            program_reg(REG_WINDOW_END, c_end);
            if (phase == PHASES - 1)
                idling = 1'b0;

            while (items_sent < (phase + 1) * PHASE_ITEMS)
            begin
                n = $urandom_range(8, 1);
                noisy = ($urandom_range(4, 0) == 0);
                sender_calm = ($urandom_range(3, 0) == 0);
                case ($urandom_range(9, 0))
                    0, 1, 2, 3, 4: anchor = cfg_win_start;
                    5, 6, 7:       anchor = cfg_win_end;
                    default:       anchor = $urandom;
                endcase
                cur_t = longint'(anchor) + longint'($urandom_range(6000, 0)) - 3000;
                cur_a = longint'(cfg_threshold) + longint'($urandom_range(3000, 0));
                for (int k = 0; k < n; k++)
                begin
                    if (noisy && $urandom_range(1, 0) == 1)
                    begin
                        st = $urandom;
                        sa = $urandom;
                    end
                    else
                    begin
                        st = clamp_time(cur_t);
                        sa = clamp_alt(cur_a);
                        cur_t = longint'(st);
                        cur_a = longint'(sa);
                    end
                    send_sample(st, sa, k == n - 1, 1'b0, 1'b0, '0);
                    items_sent++;
                    maybe_pause();
                    dt = longint'($urandom_range(1000, 0));
                    cur_t = ($urandom_range(9, 0) == 0) ? cur_t - dt : cur_t + dt;
                    // altitude drifts downward
                    cur_a = cur_a + longint'($urandom_range(1000, 0)) - 700;
                end
                if (idling && $urandom_range(39, 0) == 0)
                    drain_results();
            end
        end

        settle_block();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/tctf_pkg.sv
rtl/tctf_regs.sv
rtl/tctf_muldiv.sv
rtl/threshold_crossing_time_finder_top.sv
tb/threshold_crossing_time_finder_top_tb.sv
